/* rtl/zip64_extra_field_parser_unit_assert.svh */
// Assertion macros for the zip64 extra field parser.
// Included by the top level; no other dependencies.
`ifndef ZIP64_EXTRA_FIELD_PARSER_UNIT_ASSERT_SVH
`define ZIP64_EXTRA_FIELD_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define Z64_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
`define Z64_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define Z64_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define Z64_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

/* rtl/z64efp_pkg.sv */
// Shared types and codes for the zip64 extra field parser.
// No dependencies.
package z64efp_pkg;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [1:0] ST_PARSED      = 2'd0;
  localparam logic [1:0] ST_NO_SENTINEL = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND   = 2'd2;
  localparam logic [1:0] ST_TRUNCATED   = 2'd3;

  // want flag bit positions
  localparam int W_UNC  = 0;
  localparam int W_COMP = 1;
  localparam int W_OFF  = 2;
  localparam int W_DISK = 3;

  localparam logic [15:0] ZIP64_ID = 16'h0001;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [31:0] compressed_size_32;
    logic [31:0] uncompressed_size_32;
    logic [31:0] header_offset_32;
    logic [15:0] disk_start_16;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_uncompressed;
    logic        has_compressed;
    logic        has_offset;
    logic        has_disk;
    logic [63:0] uncompressed_size;
    logic [63:0] compressed_size;
    logic [63:0] header_offset;
    logic [31:0] disk_start;
  } res_t;

endpackage

/* rtl/z64efp_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing; field widths follow the package types.
interface z64efp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic [31:0] compressed_size_32;
  logic [31:0] uncompressed_size_32;
  logic [31:0] header_offset_32;
  logic [15:0] disk_start_16;

  modport source (output valid, action, data_byte, compressed_size_32,
                  uncompressed_size_32, header_offset_32, disk_start_16,
                  input ready);
  modport sink (input valid, action, data_byte, compressed_size_32,
                uncompressed_size_32, header_offset_32, disk_start_16,
                output ready);
endinterface

interface z64efp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        has_uncompressed;
  logic        has_compressed;
  logic        has_offset;
  logic        has_disk;
  logic [63:0] uncompressed_size;
  logic [63:0] compressed_size;
  logic [63:0] header_offset;
  logic [31:0] disk_start;

  modport source (output valid, status, has_uncompressed, has_compressed, has_offset,
                  has_disk, uncompressed_size, compressed_size, header_offset,
                  disk_start, input ready);
  modport sink (input valid, status, has_uncompressed, has_compressed, has_offset,
                has_disk, uncompressed_size, compressed_size, header_offset,
                disk_start, output ready);
endinterface

/* rtl/zip64_extra_field_parser_unit.sv */
// zip64 extra field parser: one record per start/data.../end item sequence.
// Throughput: one item per cycle unless the skid is full; items act on walker state when taken.
// The result of an end item is registered in the result register, or in the skid if it is held.
// A two-entry result buffer (result register plus skid) lets input flow while a result waits.
// Reset (rst, synchronous): walker goes idle, result buffer empties. Depends on z64efp_pkg.
`include "zip64_extra_field_parser_unit_assert.svh"
module zip64_extra_field_parser_unit #(
  parameter int MAX_EXTRA_BYTES = 65535
) (
  input logic         clk,
  input logic         rst,
  z64efp_in_if.sink   in_item,
  z64efp_out_if.source out_item
);

  z64efp_pkg::in_t  item;
  z64efp_pkg::res_t core_res;
  logic             core_valid;
  logic             accept;

  // result register and its skid entry
  z64efp_pkg::res_t or_data, sk_data;
  logic             or_valid, sk_valid;
  logic             pop;

  assign item.action               = in_item.action;
  assign item.data_byte            = in_item.data_byte;
  assign item.compressed_size_32   = in_item.compressed_size_32;
  assign item.uncompressed_size_32 = in_item.uncompressed_size_32;
  assign item.header_offset_32     = in_item.header_offset_32;
  assign item.disk_start_16        = in_item.disk_start_16;

  // Input stalls only when both result slots are taken; a full skid
  // entry means the result register is also occupied.
  assign in_item.ready = !sk_valid;
  assign accept        = in_item.valid && in_item.ready;

  z64efp_core #(
    .MAX_EXTRA_BYTES(MAX_EXTRA_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .res_valid(core_valid),
    .res      (core_res)
  );

  assign pop = or_valid && out_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      or_valid <= 1'b0;
      sk_valid <= 1'b0;
    end else begin
      if (!or_valid || pop) begin
        // skid entry drains first; a new result cannot arrive while it is full
        if (sk_valid) begin
          or_valid <= 1'b1;
          sk_valid <= 1'b0;
        end else begin
          or_valid <= core_valid;
        end
      end else if (core_valid) begin
        sk_valid <= 1'b1;
      end
    end
    if (!or_valid || pop) begin
      or_data <= sk_valid ? sk_data : core_res;
    end else if (core_valid) begin
      sk_data <= core_res;
    end
  end

  assign out_item.valid             = or_valid;
  assign out_item.status            = or_data.status;
  assign out_item.has_uncompressed  = or_data.has_uncompressed;
  assign out_item.has_compressed    = or_data.has_compressed;
  assign out_item.has_offset        = or_data.has_offset;
  assign out_item.has_disk          = or_data.has_disk;
  assign out_item.uncompressed_size = or_data.uncompressed_size;
  assign out_item.compressed_size   = or_data.compressed_size;
  assign out_item.header_offset     = or_data.header_offset;
  assign out_item.disk_start        = or_data.disk_start;

  // skid is only ever filled behind an occupied result register
  `Z64_ASSERT_IMP(a_skid_behind_out, clk, rst, sk_valid, or_valid, "skid full, output empty")
  // no new result may show up while the buffer is full
  `Z64_ASSERT_IMP(a_no_overflow, clk, rst, core_valid, !sk_valid, "result lost in full buffer")
  // a stalled result with a waiting skid entry keeps both
  `Z64_ASSERT_NXT(a_hold_skid, clk, rst, sk_valid && !out_item.ready, sk_valid && or_valid,
    "buffered result dropped")
  // only a parsed record reports values
  `Z64_ASSERT_IMP(a_flags_only_parsed, clk, rst,
    or_valid && (or_data.status != z64efp_pkg::ST_PARSED),
    !or_data.has_uncompressed && !or_data.has_compressed && !or_data.has_offset &&
    !or_data.has_disk, "value flag set on failed record")

endmodule

/* rtl/z64efp_core.sv */
// Extra field walker: subfield header scan, skip and zip64 value capture.
// Depends on z64efp_pkg.
module z64efp_core #(
  parameter int MAX_EXTRA_BYTES = 65535
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  z64efp_pkg::in_t   item,
  output logic              res_valid,
  output z64efp_pkg::res_t  res
);

  localparam int POS_W = $clog2(MAX_EXTRA_BYTES + 1);
  localparam int END_W = $clog2(MAX_EXTRA_BYTES + 65536);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_EXTRA_BYTES);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_SKIP    = 2'd2;
  localparam logic [1:0] PH_CAPTURE = 2'd3;

  logic [1:0]       phase, phase_next;
  logic [3:0]       flags, flags_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [31:0]      hb, hb_next;
  logic [15:0]      skip, skip_next;
  logic [END_W-1:0] sub_end, sub_end_next;
  logic [4:0]       cc, cc_next;
  logic [63:0]      unc, unc_next;
  logic [63:0]      comp, comp_next;
  logic [63:0]      off, off_next;
  logic [31:0]      disk, disk_next;

  logic [4:0] needed, b_comp, b_off, b_disk;
  logic [4:0] i_comp, i_off, i_disk;
  logic       we_unc, we_comp, we_off, we_disk;

  // capture layout: values packed back to back in the fixed order
  assign b_comp = flags[z64efp_pkg::W_UNC] ? 5'd8 : 5'd0;
  assign b_off  = b_comp + (flags[z64efp_pkg::W_COMP] ? 5'd8 : 5'd0);
  assign b_disk = b_off + (flags[z64efp_pkg::W_OFF] ? 5'd8 : 5'd0);
  assign needed = b_disk + (flags[z64efp_pkg::W_DISK] ? 5'd4 : 5'd0);

  assign i_comp = cc - b_comp;
  assign i_off  = cc - b_off;
  assign i_disk = cc - b_disk;

  assign we_unc  = flags[z64efp_pkg::W_UNC] && (cc < 5'd8);
  assign we_comp = flags[z64efp_pkg::W_COMP] && (cc >= b_comp) && (cc < b_comp + 5'd8);
  assign we_off  = flags[z64efp_pkg::W_OFF] && (cc >= b_off) && (cc < b_off + 5'd8);
  assign we_disk = flags[z64efp_pkg::W_DISK] && (cc >= b_disk) && (cc < b_disk + 5'd4);

  always_comb begin
    logic [31:0] hb_full;
    logic        ok;
    hb_full      = hb;
    ok           = 1'b0;
    phase_next   = phase;
    flags_next   = flags;
    pos_next     = pos;
    hb_next      = hb;
    skip_next    = skip;
    sub_end_next = sub_end;
    cc_next      = cc;
    unc_next     = unc;
    comp_next    = comp;
    off_next     = off;
    disk_next    = disk;
    res_valid    = 1'b0;
    res          = '0;
    hb_full[{cc[1:0], 3'b000} +: 8] = item.data_byte;
    if (accept) begin
      unique case (item.action)
        z64efp_pkg::ACT_START: begin
          flags_next[z64efp_pkg::W_UNC]  = &item.uncompressed_size_32;
          flags_next[z64efp_pkg::W_COMP] = &item.compressed_size_32;
          flags_next[z64efp_pkg::W_OFF]  = &item.header_offset_32;
          flags_next[z64efp_pkg::W_DISK] = &item.disk_start_16;
          phase_next   = PH_HEADER;
          pos_next     = '0;
          hb_next      = '0;
          skip_next    = '0;
          sub_end_next = '0;
          cc_next      = '0;
          unc_next     = '0;
          comp_next    = '0;
          off_next     = '0;
          disk_next    = '0;
        end
        z64efp_pkg::ACT_DATA: begin
          if (phase != PH_IDLE && pos < POS_MAX) begin
            pos_next = pos + 1'b1;
            unique case (phase)
              PH_HEADER: begin
                hb_next = hb_full;
                cc_next = cc + 5'd1;
                if (cc[1:0] == 2'd3) begin
                  if (hb_full[15:0] == z64efp_pkg::ZIP64_ID) begin
                    sub_end_next = END_W'(pos_next) + END_W'(hb_full[31:16]);
                    phase_next   = PH_CAPTURE;
                    cc_next      = '0;
                  end else if (hb_full[31:16] == 16'd0) begin
                    hb_next = '0;
                    cc_next = '0;
                  end else begin
                    skip_next  = hb_full[31:16];
                    phase_next = PH_SKIP;
                  end
                end
              end
              PH_SKIP: begin
                skip_next = skip - 16'd1;
                if (skip == 16'd1) begin
                  phase_next = PH_HEADER;
                  hb_next    = '0;
                  cc_next    = '0;
                end
              end
              PH_CAPTURE: begin
                if (cc < needed) begin
                  if (we_unc)  unc_next[{cc[2:0], 3'b000} +: 8]      = item.data_byte;
                  if (we_comp) comp_next[{i_comp[2:0], 3'b000} +: 8] = item.data_byte;
                  if (we_off)  off_next[{i_off[2:0], 3'b000} +: 8]   = item.data_byte;
                  if (we_disk) disk_next[{i_disk[1:0], 3'b000} +: 8] = item.data_byte;
                  cc_next = cc + 5'd1;
                end
              end
              default: ;
            endcase
          end
        end
        z64efp_pkg::ACT_END: begin
          if (phase != PH_IDLE) begin
            res_valid = 1'b1;
            if (flags == 4'd0) begin
              res.status = z64efp_pkg::ST_NO_SENTINEL;
            end else if (phase != PH_CAPTURE || sub_end > END_W'(pos)) begin
              res.status = z64efp_pkg::ST_NOT_FOUND;
            end else if (cc < needed) begin
              res.status = z64efp_pkg::ST_TRUNCATED;
            end else begin
              res.status = z64efp_pkg::ST_PARSED;
              ok         = 1'b1;
            end
            if (ok) begin
              res.has_uncompressed  = flags[z64efp_pkg::W_UNC];
              res.has_compressed    = flags[z64efp_pkg::W_COMP];
              res.has_offset        = flags[z64efp_pkg::W_OFF];
              res.has_disk          = flags[z64efp_pkg::W_DISK];
              res.uncompressed_size = unc;
              res.compressed_size   = comp;
              res.header_offset     = off;
              res.disk_start        = disk;
            end
            phase_next = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
    flags   <= flags_next;
    pos     <= pos_next;
    hb      <= hb_next;
    skip    <= skip_next;
    sub_end <= sub_end_next;
    cc      <= cc_next;
    unc     <= unc_next;
    comp    <= comp_next;
    off     <= off_next;
    disk    <= disk_next;
  end

endmodule
